### rtl/grm_pkg.sv
// Shared definitions for the gamepad report remapper: field widths, register
// indexes and reset values, feedback codes, and the fixed-point conversion functions.
// No dependencies.
package grm_pkg;

    localparam int DPAD_W     = 4;
    localparam int BTN_W      = 10;
    localparam int SYS_W      = 4;
    localparam int TRIG_W     = 10;
    localparam int AXIS_W     = 12;
    localparam int ACCEL_EW   = 18;
    localparam int GYRO_EW    = 21;
    localparam int ACCEL_IN_W = 3 * ACCEL_EW;
    localparam int GYRO_IN_W  = 3 * GYRO_EW;
    localparam int CONS_W     = 18;
    localparam int STICK_W    = 16;
    localparam int MOTION_W   = 48;
    localparam int EV_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_CHORD_BTN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_CHORD_SYS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_CHORD_DPAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_CHORD_BTN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_CHORD_SYS  = 3'd5;

    localparam logic [TRIG_W-1:0] RST_TRIGGER_THRESHOLD = 10'd358;
    localparam logic [BTN_W-1:0]  RST_SWAP_CHORD_BTN    = 10'd768;
    localparam logic [SYS_W-1:0]  RST_SWAP_CHORD_SYS    = 4'd1;
    localparam logic [DPAD_W-1:0] RST_MOTION_CHORD_DPAD = 4'd1;
    localparam logic [BTN_W-1:0]  RST_MOTION_CHORD_BTN  = 10'd768;
    localparam logic [SYS_W-1:0]  RST_MOTION_CHORD_SYS  = 4'd1;

    // Feedback event codes.
    localparam logic [EV_W-1:0] EV_NONE       = 2'd0;
    localparam logic [EV_W-1:0] EV_SWAP       = 2'd1;
    localparam logic [EV_W-1:0] EV_MOTION_ON  = 2'd2;
    localparam logic [EV_W-1:0] EV_MOTION_OFF = 2'd3;

    localparam int STICK_MID = 32768;
    // floor(v * 63 / 511) for v in 1..511 equals (v * 32320) >> 18.
    localparam int STICK_RECIP = 32320;

    // The gyro scale 13371 / (1024 * 936) reduces to 4457 / (8192 * 39).
    // Rounding half away from zero adds half the divisor to the magnitude.
    localparam int GYRO_PRE_W    = 33;
    localparam int GYRO_PRE_MUL  = 4457;
    localparam int GYRO_PRE_BIAS = 159744;
    // floor(m / 39) for m below 2^20 equals (m * 1720741) >> 26.
    localparam int GYRO_RECIP    = 1720741;

    typedef struct packed {
        logic [TRIG_W-1:0] trigger_threshold;
        logic [BTN_W-1:0]  swap_btn;
        logic [SYS_W-1:0]  swap_sys;
        logic [DPAD_W-1:0] motion_dpad;
        logic [BTN_W-1:0]  motion_btn;
        logic [SYS_W-1:0]  motion_sys;
    } t_cfg;

    // Hotkey stage result: masked report bits and the toggles after this word.
    typedef struct packed {
        logic [DPAD_W-1:0] dpad;
        logic [BTN_W-1:0]  btn;
        logic [SYS_W-1:0]  sys;
        logic              swap;
        logic              motion;
        logic [EV_W-1:0]   event_code;
    } t_hotkey;

    typedef struct packed {
        logic [CONS_W-1:0]   console_buttons;
        logic [STICK_W-1:0]  left_x;
        logic [STICK_W-1:0]  left_y;
        logic [STICK_W-1:0]  right_x;
        logic [STICK_W-1:0]  right_y;
        logic                motion_valid;
        logic [MOTION_W-1:0] accel;
        logic [MOTION_W-1:0] gyro;
        logic [EV_W-1:0]     feedback_event;
        logic                swap_active;
        logic                motion_active;
    } t_result;

    // Clamp to -512..511 and map onto 0..65535 with 32768 at center.
    function automatic logic [STICK_W-1:0] f_scale_axis(input logic signed [AXIS_W-1:0] raw);
        logic signed [9:0] c;
        logic [9:0]        low;
        logic [8:0]        pos;
        logic [23:0]       prod;
        if (raw < -12'sd512) begin
            c = -10'sd512;
        end else if (raw > 12'sd511) begin
            c = 10'sd511;
        end else begin
            c = $signed(raw[9:0]);
        end
        // c + 512 is c with its sign bit flipped.
        low  = {~c[9], c[8:0]};
        pos  = c[8:0];
        prod = 24'(pos) * 24'(STICK_RECIP);
        if (c[9] || (c == 10'sd0)) begin
            return {low, 6'b0};
        end
        return 16'(STICK_MID) + {1'b0, pos, 6'b0} + 16'(prod[23:18]);
    endfunction

    // Optionally negate, halve toward zero, saturate to int16.
    function automatic logic [15:0] f_accel(input logic signed [ACCEL_EW-1:0] a,
                                            input logic neg);
        logic signed [ACCEL_EW:0] v;
        logic signed [ACCEL_EW:0] t;
        logic signed [ACCEL_EW:0] h;
        v = {a[ACCEL_EW-1], a};
        if (neg) begin
            v = -v;
        end
        t = v + $signed({{ACCEL_EW{1'b0}}, v[ACCEL_EW]});
        h = t >>> 1;
        if (h > 19'sd32767) begin
            return 16'h7FFF;
        end else if (h < -19'sd32768) begin
            return 16'h8000;
        end
        return h[15:0];
    endfunction

    // Magnitude times the reduced numerator, plus the rounding bias.
    function automatic logic [GYRO_PRE_W-1:0] f_gyro_pre(input logic signed [GYRO_EW-1:0] g);
        logic [GYRO_EW-1:0] mag;
        mag = g[GYRO_EW-1] ? GYRO_EW'(-g) : g;
        return GYRO_PRE_W'(mag) * GYRO_PRE_W'(GYRO_PRE_MUL) + GYRO_PRE_W'(GYRO_PRE_BIAS);
    endfunction

    // Divide by 8192 * 39 and apply the sign. The quotient stays below
    // 14629, so the int16 limits are never reached.
    function automatic logic [15:0] f_gyro_post(input logic [GYRO_PRE_W-1:0] y,
                                                input logic neg);
        logic [19:0] m;
        logic [40:0] p;
        logic [15:0] q;
        m = y[32:13];
        p = 41'(m) * 41'(GYRO_RECIP);
        q = {1'b0, p[40:26]};
        return neg ? (~q + 16'd1) : q;
    endfunction

endpackage

### rtl/gamepad_report_remapper.sv
// Top level of the gamepad report remapper: configuration registers, input
// register, output register and handshake. Uses grm_pkg, grm_hotkey and grm_map.

// One report word goes in and one console word comes out per clock, sustained while each
// result is taken when offered. A report passes through both registers in turn. The
// input register takes the report together with the gyro magnitude products,
// and the output register takes the mapped result after the hotkey and mapping
// logic. The output register frees the input side, so a new report is accepted
// while a result waits. The input side stalls only when both registers are full
// and the waiting result is not taken in that cycle.
// The swap and motion toggles advance as each report moves into the output
// register, so hotkey effects follow report order exactly. Configuration is
// written through a plain write port and should only change while idle.
module gamepad_report_remapper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [grm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [grm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [grm_pkg::DPAD_W-1:0]     i_dpad_bits,
    input  logic [grm_pkg::BTN_W-1:0]      i_button_bits,
    input  logic [grm_pkg::SYS_W-1:0]      i_system_bits,
    input  logic [grm_pkg::TRIG_W-1:0]     i_brake_level,
    input  logic [grm_pkg::TRIG_W-1:0]     i_throttle_level,
    input  logic signed [grm_pkg::AXIS_W-1:0] i_left_x_raw,
    input  logic signed [grm_pkg::AXIS_W-1:0] i_left_y_raw,
    input  logic signed [grm_pkg::AXIS_W-1:0] i_right_x_raw,
    input  logic signed [grm_pkg::AXIS_W-1:0] i_right_y_raw,
    input  logic [grm_pkg::ACCEL_IN_W-1:0] i_accel_raw_packed,
    input  logic [grm_pkg::GYRO_IN_W-1:0]  i_gyro_raw_packed,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [grm_pkg::CONS_W-1:0]     o_console_buttons,
    output logic [grm_pkg::STICK_W-1:0]    o_left_x_out,
    output logic [grm_pkg::STICK_W-1:0]    o_left_y_out,
    output logic [grm_pkg::STICK_W-1:0]    o_right_x_out,
    output logic [grm_pkg::STICK_W-1:0]    o_right_y_out,
    output logic                           o_motion_valid,
    output logic [grm_pkg::MOTION_W-1:0]   o_accel_out_packed,
    output logic [grm_pkg::MOTION_W-1:0]   o_gyro_out_packed,
    output logic [grm_pkg::EV_W-1:0]       o_feedback_event,
    output logic                           o_swap_active,
    output logic                           o_motion_active
);
    import grm_pkg::*;

    t_cfg    r_cfg;
    t_hotkey hk_res;
    t_result map_res;
    t_result r_out;

    logic r_s1_valid, n_s1_valid;
    logic r_out_valid, n_out_valid;
    logic in_acc, advance, s2_free;

    logic [DPAD_W-1:0]     r_s1_dpad;
    logic [BTN_W-1:0]      r_s1_btn;
    logic [SYS_W-1:0]      r_s1_sys;
    logic [TRIG_W-1:0]     r_s1_brake;
    logic [TRIG_W-1:0]     r_s1_throttle;
    logic [AXIS_W-1:0]     r_s1_left_x;
    logic [AXIS_W-1:0]     r_s1_left_y;
    logic [AXIS_W-1:0]     r_s1_right_x;
    logic [AXIS_W-1:0]     r_s1_right_y;
    logic [ACCEL_IN_W-1:0] r_s1_accel;
    logic [GYRO_IN_W-1:0]  r_s1_gyro;
    logic [GYRO_PRE_W-1:0] r_s1_gyro_pre [3];
    logic [GYRO_PRE_W-1:0] gyro_pre [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_threshold <= RST_TRIGGER_THRESHOLD;
            r_cfg.swap_btn          <= RST_SWAP_CHORD_BTN;
            r_cfg.swap_sys          <= RST_SWAP_CHORD_SYS;
            r_cfg.motion_dpad       <= RST_MOTION_CHORD_DPAD;
            r_cfg.motion_btn        <= RST_MOTION_CHORD_BTN;
            r_cfg.motion_sys        <= RST_MOTION_CHORD_SYS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRIGGER_THRESHOLD: r_cfg.trigger_threshold <= i_cfg_data;
                CFG_SWAP_CHORD_BTN:    r_cfg.swap_btn          <= i_cfg_data;
                CFG_SWAP_CHORD_SYS:    r_cfg.swap_sys          <= i_cfg_data[SYS_W-1:0];
                CFG_MOTION_CHORD_DPAD: r_cfg.motion_dpad       <= i_cfg_data[DPAD_W-1:0];
                CFG_MOTION_CHORD_BTN:  r_cfg.motion_btn        <= i_cfg_data;
                CFG_MOTION_CHORD_SYS:  r_cfg.motion_sys        <= i_cfg_data[SYS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s2_free     = !r_out_valid || i_out_ready;
        advance     = r_s1_valid && s2_free;
        o_in_ready  = !r_s1_valid || s2_free;
        in_acc      = i_in_valid && o_in_ready;
        n_s1_valid  = in_acc ? 1'b1 : (advance ? 1'b0 : r_s1_valid);
        n_out_valid = advance ? 1'b1 : ((r_out_valid && i_out_ready) ? 1'b0 : r_out_valid);
        for (int i = 0; i < 3; i++) begin
            gyro_pre[i] = f_gyro_pre($signed(i_gyro_raw_packed[GYRO_EW*i +: GYRO_EW]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_dpad     <= i_dpad_bits;
            r_s1_btn      <= i_button_bits;
            r_s1_sys      <= i_system_bits;
            r_s1_brake    <= i_brake_level;
            r_s1_throttle <= i_throttle_level;
            r_s1_left_x   <= i_left_x_raw;
            r_s1_left_y   <= i_left_y_raw;
            r_s1_right_x  <= i_right_x_raw;
            r_s1_right_y  <= i_right_y_raw;
            r_s1_accel    <= i_accel_raw_packed;
            r_s1_gyro     <= i_gyro_raw_packed;
            r_s1_gyro_pre <= gyro_pre;
        end
        if (advance) begin
            r_out <= map_res;
        end
    end

    grm_hotkey u_hotkey (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cfg     (r_cfg),
        .i_dpad    (r_s1_dpad),
        .i_btn     (r_s1_btn),
        .i_sys     (r_s1_sys),
        .o_res     (hk_res)
    );

    grm_map u_map (
        .i_hk        (hk_res),
        .i_threshold (r_cfg.trigger_threshold),
        .i_brake     (r_s1_brake),
        .i_throttle  (r_s1_throttle),
        .i_left_x    (r_s1_left_x),
        .i_left_y    (r_s1_left_y),
        .i_right_x   (r_s1_right_x),
        .i_right_y   (r_s1_right_y),
        .i_accel_raw (r_s1_accel),
        .i_gyro_raw  (r_s1_gyro),
        .i_gyro_pre  (r_s1_gyro_pre),
        .o_res       (map_res)
    );

    assign o_out_valid        = r_out_valid;
    assign o_console_buttons  = r_out.console_buttons;
    assign o_left_x_out       = r_out.left_x;
    assign o_left_y_out       = r_out.left_y;
    assign o_right_x_out      = r_out.right_x;
    assign o_right_y_out      = r_out.right_y;
    assign o_motion_valid     = r_out.motion_valid;
    assign o_accel_out_packed = r_out.accel;
    assign o_gyro_out_packed  = r_out.gyro;
    assign o_feedback_event   = r_out.feedback_event;
    assign o_swap_active      = r_out.swap_active;
    assign o_motion_active    = r_out.motion_active;

endmodule

### rtl/grm_hotkey.sv
// Hotkey chord detection for the report remapper: swap and motion toggles,
// edge tracking, feedback event and chord bit suppression. Uses grm_pkg.
module grm_hotkey (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  grm_pkg::t_cfg              i_cfg,
    input  logic [grm_pkg::DPAD_W-1:0] i_dpad,
    input  logic [grm_pkg::BTN_W-1:0]  i_btn,
    input  logic [grm_pkg::SYS_W-1:0]  i_sys,
    output grm_pkg::t_hotkey           o_res
);
    import grm_pkg::*;

    logic r_swap_toggle, n_swap_toggle;
    logic r_motion_toggle, n_motion_toggle;
    logic r_swap_seen, r_motion_seen;
    logic swap_now, motion_now, swap_rise, motion_rise;

    always_comb begin
        swap_now   = ((i_btn & i_cfg.swap_btn) == i_cfg.swap_btn) &&
                     ((i_sys & i_cfg.swap_sys) == i_cfg.swap_sys);
        motion_now = ((i_dpad & i_cfg.motion_dpad) == i_cfg.motion_dpad) &&
                     ((i_btn & i_cfg.motion_btn) == i_cfg.motion_btn) &&
                     ((i_sys & i_cfg.motion_sys) == i_cfg.motion_sys);
        // The swap chord wins when both rise on the same word.
        swap_rise   = swap_now && !r_swap_seen;
        motion_rise = motion_now && !r_motion_seen && !swap_rise;
        n_swap_toggle   = r_swap_toggle ^ swap_rise;
        n_motion_toggle = r_motion_toggle ^ motion_rise;

        o_res.swap   = n_swap_toggle;
        o_res.motion = n_motion_toggle;
        priority if (swap_rise) begin
            o_res.event_code = EV_SWAP;
        end else if (motion_rise) begin
            o_res.event_code = n_motion_toggle ? EV_MOTION_ON : EV_MOTION_OFF;
        end else begin
            o_res.event_code = EV_NONE;
        end

        o_res.dpad = i_dpad & ~(motion_now ? i_cfg.motion_dpad : '0);
        o_res.btn  = i_btn & ~(swap_now ? i_cfg.swap_btn : '0)
                           & ~(motion_now ? i_cfg.motion_btn : '0);
        o_res.sys  = i_sys & ~(swap_now ? i_cfg.swap_sys : '0)
                           & ~(motion_now ? i_cfg.motion_sys : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap_toggle   <= 1'b0;
            r_motion_toggle <= 1'b1;
            r_swap_seen     <= 1'b0;
            r_motion_seen   <= 1'b0;
        end else if (i_advance) begin
            r_swap_toggle   <= n_swap_toggle;
            r_motion_toggle <= n_motion_toggle;
            r_swap_seen     <= swap_now;
            r_motion_seen   <= motion_now;
        end
    end

endmodule

### rtl/grm_map.sv
// Console report mapping: button vector with face swap and trigger thresholds,
// stick scaling, and accelerometer and gyro conversion. Uses grm_pkg.
module grm_map (
    input  grm_pkg::t_hotkey                i_hk,
    input  logic [grm_pkg::TRIG_W-1:0]      i_threshold,
    input  logic [grm_pkg::TRIG_W-1:0]      i_brake,
    input  logic [grm_pkg::TRIG_W-1:0]      i_throttle,
    input  logic [grm_pkg::AXIS_W-1:0]      i_left_x,
    input  logic [grm_pkg::AXIS_W-1:0]      i_left_y,
    input  logic [grm_pkg::AXIS_W-1:0]      i_right_x,
    input  logic [grm_pkg::AXIS_W-1:0]      i_right_y,
    input  logic [grm_pkg::ACCEL_IN_W-1:0]  i_accel_raw,
    input  logic [grm_pkg::GYRO_IN_W-1:0]   i_gyro_raw,
    input  logic [grm_pkg::GYRO_PRE_W-1:0]  i_gyro_pre [3],
    output grm_pkg::t_result                o_res
);
    import grm_pkg::*;

    logic ca, cb, cx, cy;
    logic [ACCEL_EW-1:0] a0, a1, a2;
    logic [GYRO_EW-1:0]  g0, g1, g2;
    logic valid;

    always_comb begin
        a0 = i_accel_raw[ACCEL_EW-1:0];
        a1 = i_accel_raw[2*ACCEL_EW-1:ACCEL_EW];
        a2 = i_accel_raw[3*ACCEL_EW-1:2*ACCEL_EW];
        g0 = i_gyro_raw[GYRO_EW-1:0];
        g1 = i_gyro_raw[2*GYRO_EW-1:GYRO_EW];
        g2 = i_gyro_raw[3*GYRO_EW-1:2*GYRO_EW];

        if (i_hk.swap) begin
            ca = i_hk.btn[0];
            cb = i_hk.btn[1];
            cx = i_hk.btn[2];
            cy = i_hk.btn[3];
        end else begin
            cb = i_hk.btn[0];
            ca = i_hk.btn[1];
            cy = i_hk.btn[2];
            cx = i_hk.btn[3];
        end

        o_res.console_buttons = {
            i_hk.btn[6] || (i_brake >= i_threshold),
            i_hk.btn[4],
            i_hk.dpad[3], i_hk.dpad[2], i_hk.dpad[0], i_hk.dpad[1],
            i_hk.sys[3], i_hk.sys[0],
            i_hk.btn[8], i_hk.btn[9],
            i_hk.sys[2], i_hk.sys[1],
            i_hk.btn[7] || (i_throttle >= i_threshold),
            i_hk.btn[5],
            ca, cb, cx, cy
        };

        o_res.left_x  = f_scale_axis($signed(i_left_x));
        o_res.left_y  = f_scale_axis($signed(i_left_y));
        o_res.right_x = f_scale_axis($signed(i_right_x));
        o_res.right_y = f_scale_axis($signed(i_right_y));

        valid = i_hk.motion && ((i_accel_raw != '0) || (i_gyro_raw != '0));
        o_res.motion_valid = valid;
        if (valid) begin
            o_res.accel = {f_accel($signed(a1), 1'b0),
                           f_accel($signed(a0), 1'b1),
                           f_accel($signed(a2), 1'b1)};
            // A negated axis comes out negative when its raw value is positive.
            o_res.gyro  = {f_gyro_post(i_gyro_pre[1], g1[GYRO_EW-1]),
                           f_gyro_post(i_gyro_pre[0], !g0[GYRO_EW-1]),
                           f_gyro_post(i_gyro_pre[2], !g2[GYRO_EW-1])};
        end else begin
            o_res.accel = '0;
            o_res.gyro  = '0;
        end

        o_res.feedback_event = i_hk.event_code;
        o_res.swap_active    = i_hk.swap;
        o_res.motion_active  = i_hk.motion;
    end

endmodule

### rtl/grm_checker.sv
// Port-level checks for the gamepad report remapper, attached by the bind
// statement at the end of this file. Uses grm_pkg.
module grm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [grm_pkg::CONS_W-1:0]   o_console_buttons,
    input logic                         o_motion_valid,
    input logic [grm_pkg::MOTION_W-1:0] o_accel_out_packed,
    input logic [grm_pkg::MOTION_W-1:0] o_gyro_out_packed,
    input logic [grm_pkg::EV_W-1:0]     o_feedback_event,
    input logic                         o_swap_active,
    input logic                         o_motion_active
);
    import grm_pkg::*;

    logic out_acc;
    logic r_prev_swap, r_prev_motion;

    assign out_acc = o_out_valid && i_out_ready;

    // Toggle values of the last delivered word, starting from the reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_swap   <= 1'b0;
            r_prev_motion <= 1'b1;
        end else if (out_acc) begin
            r_prev_swap   <= o_swap_active;
            r_prev_motion <= o_motion_active;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_console_buttons) &&
            $stable(o_feedback_event))
        else $error("result word changed while stalled");

    a_swap_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> ((o_swap_active != r_prev_swap) == (o_feedback_event == EV_SWAP)))
        else $error("swap setting and swap event disagree");

    a_motion_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> ((o_motion_active != r_prev_motion) ==
            (o_feedback_event == EV_MOTION_ON || o_feedback_event == EV_MOTION_OFF)) &&
            (o_feedback_event != EV_MOTION_ON || o_motion_active) &&
            (o_feedback_event != EV_MOTION_OFF || !o_motion_active))
        else $error("motion setting and motion event disagree");

    a_motion_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_motion_valid ? o_motion_active :
            (o_accel_out_packed == '0 && o_gyro_out_packed == '0)))
        else $error("motion data present without valid motion");

endmodule

bind gamepad_report_remapper grm_checker u_grm_checker (.*);
